/* rtl/spi_channel_immediate_transfer_core_assert.svh */
// ----------------------------------------------------------------------------
// SPI channel assertion macros
// Shared property macros for the checker of the SPI channel core.
// ----------------------------------------------------------------------------
`ifndef SPI_CHANNEL_IMMEDIATE_TRANSFER_CORE_ASSERT_SVH
`define SPI_CHANNEL_IMMEDIATE_TRANSFER_CORE_ASSERT_SVH

// same-cycle implication
`define SCIT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scit assertion failed");

// next-cycle implication
`define SCIT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scit assertion failed");

`endif

/* rtl/scit_pkg.sv */
// ----------------------------------------------------------------------------
// SPI channel package
// Word types, register codes and field positions of the SPI channel core.
// ----------------------------------------------------------------------------
package scit_pkg;

    localparam int FASTEST_HALF_PERIOD = 1;
    localparam int NUM_SELECTS         = 3;

    localparam logic [2:0] CS_MASK = 3'(((1 << NUM_SELECTS) - 1) & 7);

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] SEL_STATUS   = 3'd0;
    localparam logic [2:0] SEL_DMA_ADDR = 3'd1;
    localparam logic [2:0] SEL_DMA_LEN  = 3'd2;
    localparam logic [2:0] SEL_CONTROL  = 3'd3;
    localparam logic [2:0] SEL_DATA     = 3'd4;

    localparam logic [1:0] XFER_RX = 2'd0;
    localparam logic [1:0] XFER_TX = 2'd1;

    localparam int ST_DEVMASK = 0;
    localparam int ST_DEVINT  = 1;
    localparam int ST_TCMASK  = 2;
    localparam int ST_TCINT   = 3;
    localparam int ST_CLKPOS  = 4;
    localparam int ST_CSPOS   = 7;
    localparam int ST_EXTMASK = 10;
    localparam int ST_EXTINT  = 11;
    localparam int ST_PRESENT = 12;
    localparam int ST_ROMDIS  = 13;

    localparam logic [13:0] ST_KEEP  = 14'h0475;
    localparam logic [13:0] ST_FLAGS = 14'h080a;

    localparam logic [5:0] CT_WRITE_MASK = 6'h3d;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  reg_sel;
        logic [31:0] write_data;
        logic        miso;
        logic        ext_present;
        logic        device_int;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        sclk;
        logic        mosi;
        logic [2:0]  chip_selects;
        logic        irq;
        logic        busy_res;
    } result_t;

    function automatic logic [7:0] half_reload(input logic [2:0] sel);
        logic [2:0] s;
        logic [8:0] full;
        s    = (sel > 3'd6) ? 3'd6 : sel;
        full = 9'(FASTEST_HALF_PERIOD) << (3'd6 - s);
        return 8'(full - 9'd1);
    endfunction

endpackage

/* rtl/scit_engine.sv */
// ----------------------------------------------------------------------------
// SPI channel engine
// Register file, clock divider and shifter; next state for one word.
// ----------------------------------------------------------------------------
module scit_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  scit_pkg::item_t    item,
    output scit_pkg::result_t  result_next
);

    logic [13:0] status_reg,   status_next;
    logic [5:0]  control_reg,  control_next;
    logic [31:0] data_reg,     data_next;
    logic [31:0] dma_addr_reg, dma_addr_next;
    logic [31:0] dma_len_reg,  dma_len_next;
    logic [5:0]  bits_reg,     bits_next;
    logic [7:0]  div_reg,      div_next;
    logic        level_reg,    level_next;
    logic        presence_reg, presence_next;

    logic [31:0] rd;
    logic [7:0]  reload;
    logic [4:0]  pos_cur;
    logic [4:0]  pos_next;

    function automatic logic [4:0] cur_pos(input logic [5:0] ctl, input logic [5:0] left);
        logic [5:0] total;
        logic [4:0] done;
        total = (6'(ctl[5:4]) + 6'd1) << 3;
        done  = 5'(total - left);
        return 5'd31 - done;
    endfunction

    always_comb
    begin
        status_next   = status_reg;
        control_next  = control_reg;
        data_next     = data_reg;
        dma_addr_next = dma_addr_reg;
        dma_len_next  = dma_len_reg;
        bits_next     = bits_reg;
        div_next      = div_reg;
        level_next    = level_reg;
        presence_next = item.ext_present;
        rd            = '0;

        if (item.ext_present != presence_reg)
            status_next[scit_pkg::ST_EXTINT] = 1'b1;
        status_next[scit_pkg::ST_PRESENT] = item.ext_present;
        if (item.device_int)
            status_next[scit_pkg::ST_DEVINT] = 1'b1;

        reload  = scit_pkg::half_reload(status_next[scit_pkg::ST_CLKPOS +: 3]);
        pos_cur = cur_pos(control_reg, bits_reg);

        case (item.op)
            scit_pkg::OP_TICK:
            begin
                if (control_reg[0])
                begin
                    if (div_reg != 8'd0)
                        div_next = div_reg - 8'd1;
                    else
                    begin
                        div_next = reload;
                        if (!level_reg)
                        begin
                            level_next = 1'b1;
                            if (control_reg[3:2] != scit_pkg::XFER_TX)
                                data_next[pos_cur] = item.miso;
                        end
                        else
                        begin
                            level_next = 1'b0;
                            if (bits_reg != 6'd0)
                                bits_next = bits_reg - 6'd1;
                            if (bits_next == 6'd0)
                            begin
                                control_next[0] = 1'b0;
                                status_next[scit_pkg::ST_TCINT] = 1'b1;
                            end
                        end
                    end
                end
            end
            scit_pkg::OP_READ:
            begin
                case (item.reg_sel)
                    scit_pkg::SEL_STATUS:   rd = 32'(status_next);
                    scit_pkg::SEL_DMA_ADDR: rd = dma_addr_reg;
                    scit_pkg::SEL_DMA_LEN:  rd = dma_len_reg;
                    scit_pkg::SEL_CONTROL:  rd = 32'(control_reg);
                    scit_pkg::SEL_DATA:     rd = data_reg;
                    default:                rd = '0;
                endcase
            end
            scit_pkg::OP_WRITE:
            begin
                case (item.reg_sel)
                    scit_pkg::SEL_STATUS:
                    begin
                        status_next = (status_next & scit_pkg::ST_FLAGS & ~item.write_data[13:0])
                            | (item.write_data[13:0] & scit_pkg::ST_KEEP)
                            | (item.write_data[13:0]
                               & (14'(scit_pkg::CS_MASK) << scit_pkg::ST_CSPOS))
                            | (status_next & 14'(1 << scit_pkg::ST_PRESENT));
                        status_next[scit_pkg::ST_ROMDIS] = status_reg[scit_pkg::ST_ROMDIS]
                            | item.write_data[scit_pkg::ST_ROMDIS];
                    end
                    scit_pkg::SEL_DMA_ADDR: dma_addr_next = item.write_data;
                    scit_pkg::SEL_DMA_LEN:  dma_len_next  = item.write_data;
                    scit_pkg::SEL_CONTROL:
                    begin
                        if (!control_reg[0])
                        begin
                            control_next = item.write_data[5:0] & scit_pkg::CT_WRITE_MASK;
                            if (control_next[0])
                            begin
                                bits_next  = (6'(control_next[5:4]) + 6'd1) << 3;
                                div_next   = reload;
                                level_next = 1'b0;
                            end
                        end
                    end
                    scit_pkg::SEL_DATA:
                    begin
                        if (!control_reg[0])
                            data_next = item.write_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        pos_next = cur_pos(control_next, bits_next);

        result_next.read_data    = rd;
        result_next.busy_res     = control_next[0];
        result_next.sclk         = control_next[0] & level_next;
        result_next.mosi         = control_next[0] && (control_next[3:2] != scit_pkg::XFER_RX)
                                   && data_next[pos_next];
        result_next.chip_selects = status_next[scit_pkg::ST_CSPOS +: 3];
        result_next.irq =
            (status_next[scit_pkg::ST_DEVINT] & status_next[scit_pkg::ST_DEVMASK])
            | (status_next[scit_pkg::ST_TCINT] & status_next[scit_pkg::ST_TCMASK])
            | (status_next[scit_pkg::ST_EXTINT] & status_next[scit_pkg::ST_EXTMASK]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg   <= '0;
            control_reg  <= '0;
            data_reg     <= '0;
            dma_addr_reg <= '0;
            dma_len_reg  <= '0;
            bits_reg     <= '0;
            div_reg      <= '0;
            level_reg    <= 1'b0;
            presence_reg <= 1'b0;
        end
        else if (advance)
        begin
            status_reg   <= status_next;
            control_reg  <= control_next;
            data_reg     <= data_next;
            dma_addr_reg <= dma_addr_next;
            dma_len_reg  <= dma_len_next;
            bits_reg     <= bits_next;
            div_reg      <= div_next;
            level_reg    <= level_next;
            presence_reg <= presence_next;
        end
    end

endmodule

/* rtl/spi_channel_immediate_transfer_core.sv */
// ----------------------------------------------------------------------------
// SPI channel immediate transfer core
// One SPI channel behind five registers, driven by tick/read/write words.
//
//   channel  direction  handshake                   word
//   item     in         item_valid / item_ready     scit_pkg::item_t
//   result   out        result_valid / result_ready scit_pkg::result_t
//
// One word per cycle sustained while the result is not stalled; a word passes
// the input register and then the result register. The engine updates all
// channel state in the cycle a word leaves the input register. Reset clears
// the channel state and both valid flags. A stalled result holds the result
// register; the input register keeps taking words until it is full.
// ----------------------------------------------------------------------------
module spi_channel_immediate_transfer_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  scit_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_ready,
    output scit_pkg::result_t  result
);

    scit_pkg::item_t   item_reg;
    logic              item_valid_reg, item_valid_next;
    scit_pkg::result_t result_reg;
    scit_pkg::result_t result_next;
    logic              result_valid_reg, result_valid_next;
    logic              advance;
    logic              take;

    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        item_valid_next   = take ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
        result_valid_next = advance ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
    end

    scit_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (item_reg),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/scit_checker.sv */
// ----------------------------------------------------------------------------
// SPI channel checker
// Port-level properties of the SPI channel core, bound to the top level.
// ----------------------------------------------------------------------------
`include "spi_channel_immediate_transfer_core_assert.svh"

module scit_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input scit_pkg::result_t  result
);

    `SCIT_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid)
    `SCIT_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && !result_ready, $stable(result))
    `SCIT_ASSERT_NOW(a_sclk_only_busy, clk, rst_n, result_valid && result.sclk, result.busy_res)
    `SCIT_ASSERT_NOW(a_mosi_only_busy, clk, rst_n, result_valid && result.mosi, result.busy_res)

endmodule

bind spi_channel_immediate_transfer_core scit_checker u_scit_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
